// File: design/potl_pkg.sv
// Package for the priority-ordered task list: payload structs, codes and
// the minutes-to-hours helpers. No dependencies.
`default_nettype none
package potl_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned MIN_PER_HOUR = 60;
  localparam int unsigned SUM_W = 19;
  localparam int unsigned HOUR_MAX = 16383;

  typedef enum logic [2:0] {
    K_PUSH   = 3'd0,
    K_POP    = 3'd1,
    K_REMOVE = 3'd2,
    K_CHPRI  = 3'd3,
    K_UP     = 3'd4,
    K_DOWN   = 3'd5,
    K_QUERY  = 3'd6,
    K_NONE   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] task_number;
    logic [2:0]  priority_req;
    logic [7:0]  hours;
    logic [5:0]  minutes;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_task_number;
    logic [2:0]  out_priority;
    logic [13:0] out_hours;
    logic [5:0]  out_minutes;
    logic [5:0]  entry_count;
    logic [13:0] total_hours;
    logic [5:0]  total_minutes;
  } rsp_t;

  typedef struct packed {
    logic [15:0] num;
    logic [2:0]  pri;
    logic [7:0]  hr;
    logic [5:0]  mn;
  } slot_t;

  // Control word broadcast from the sequencer to every cell.
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_ROTL   = 3'd3,
    OP_ROTR   = 3'd4,
    OP_SWAP   = 3'd5,
    OP_SETPRI = 3'd6
  } cop_t;

  typedef struct packed {
    cop_t        op;
    logic [10:0] pos;  // insert / delete / swap / priority-write position
    logic [10:0] last; // index of the tail before the operation
    slot_t       ins;  // slot written by insert
    logic [2:0]  pri;  // search / query priority, or priority to write
    logic [15:0] num;  // search number
  } ctl_t;

  // Exact x / 60 for x < 2**19: the reciprocal estimate is low by at most
  // one, and a single compare corrects it.
  function automatic logic [SUM_W-1:0] quot60(input logic [SUM_W-1:0] x);
    logic [SUM_W+16:0] p;
    logic [SUM_W-1:0] q;
    p = {17'd0, x} * 36'd69905;
    q = {5'd0, p[SUM_W+16:22]};
    if (({6'd0, q} + 25'd1) * 25'd60 <= {6'd0, x}) q = q + 1'b1;
    return q;
  endfunction

  // Minutes value divided by 60, saturated to the hours field.
  function automatic logic [13:0] div60(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] q;
    q = quot60(x);
    return (q > SUM_W'(HOUR_MAX)) ? 14'(HOUR_MAX) : q[13:0];
  endfunction

  function automatic logic [5:0] mod60(input logic [SUM_W-1:0] x);
    logic [SUM_W+5:0] r;
    r = {6'd0, x} - ({6'd0, quot60(x)} * 25'd60);
    return r[5:0];
  endfunction

endpackage
`default_nettype wire

// File: design/potl_cell.sv
// One slot of the task chain. Holds a task and shifts with its neighbors
// under the broadcast control word. Depends on potl_pkg.
`default_nettype none
module potl_cell #(
  parameter int unsigned IDX_W = 5,
  parameter int unsigned INDEX = 0
) (
  input  wire logic            clk,
  input  potl_pkg::ctl_t       ctl,
  input  potl_pkg::slot_t      from_left,
  input  potl_pkg::slot_t      from_right,
  input  potl_pkg::slot_t      head_slot,
  input  potl_pkg::slot_t      tail_slot,
  output potl_pkg::slot_t      slot,
  output logic                 pri_gt,
  output logic                 num_eq,
  output logic                 pri_eq
);
  import potl_pkg::*;

  localparam logic [10:0] ME = 11'(INDEX);
  slot_t slot_next;

  assign pri_gt = slot.pri > ctl.pri;
  assign num_eq = slot.num == ctl.num;
  assign pri_eq = slot.pri == ctl.pri;

  always_comb begin
    slot_next = slot;
    case (ctl.op)
      OP_INSERT: begin
        if (ME == ctl.pos) slot_next = ctl.ins;
        else if (ME > ctl.pos && ME <= ctl.last + 11'd1) slot_next = from_left;
      end
      OP_DELETE: begin
        if (ME >= ctl.pos && ME < ctl.last) slot_next = from_right;
      end
      OP_ROTL: begin
        if (ME < ctl.last) slot_next = from_right;
        else if (ME == ctl.last) slot_next = head_slot;
      end
      OP_ROTR: begin
        if (ME == 11'd0) slot_next = tail_slot;
        else if (ME <= ctl.last) slot_next = from_left;
      end
      OP_SWAP: begin
        if (ME == ctl.pos) slot_next = from_right;
        else if (ME == ctl.pos + 11'd1) slot_next = from_left;
      end
      OP_SETPRI: begin
        if (ME == ctl.pos) slot_next.pri = ctl.pri;
      end
      default: slot_next = slot;
    endcase
  end

  // Slot storage has no reset; entries past the count are never read.
  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

  logic unused;
  assign unused = ^IDX_W;
endmodule
`default_nettype wire

// File: design/priority_ordered_task_list.sv
// Top level of the priority-ordered task list: sequencer, chain of cells,
// duration accumulator. Depends on potl_pkg and potl_cell.
//
// Usage: drive the request struct req and pulse start while busy is low;
// that edge accepts the transaction. Exactly one result transaction follows:
// done is high for one cycle with rsp valid. The receiver cannot stall, so
// rsp must be captured in that cycle.
// Sequence: push, pop, remove and a move-down of the tail task pass through
// the chain state (S_EXEC) and then the result state (S_DONE). Change
// priority and the other moves also pass through S_INS or S_FIX between
// them, which re-inserts the task or writes the adopted priority. A duration
// query walks the cells one per cycle through a shared adder (S_SUM) before
// the result state. The block takes one transaction at a time; busy stays
// high from accept through the done cycle, so the next transaction can be
// accepted only once the block is back in idle.
// Reset (rst, synchronous) empties the list and clears the total time.
// Slot contents are not cleared; only the first entry_count slots matter.
`default_nettype none
module priority_ordered_task_list #(
  parameter int unsigned DEPTH = potl_pkg::DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  potl_pkg::req_t     req,
  output logic               busy,
  output logic               done,
  output potl_pkg::rsp_t     rsp
);
  import potl_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_INS   = 6'b000100,
    S_FIX   = 6'b001000,
    S_SUM   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Priority fix-up after a move.
  typedef enum logic [1:0] {
    FX_UP_SWAP = 2'd0,  // moved task at fixpos adopts smaller priority of fixpos+1
    FX_UP_WRAP = 2'd1,  // moved task at fixpos+1 adopts smaller priority of fixpos
    FX_DOWN    = 2'd2   // moved task at fixpos+1 adopts greater priority of fixpos
  } fix_t;

  state_t state, state_next;
  req_t   rq;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] qsum;
  logic [IDX_W-1:0] walk;
  logic [IDX_W-1:0] fixpos;
  fix_t        fixmode;
  logic        fixen;
  slot_t       carry;   // task held between delete and re-insert, or pushed
  logic [1:0]  st;
  slot_t       popped;

  ctl_t  ctl;
  slot_t slots [DEPTH];
  logic [DEPTH-1:0] gt_v, eq_v, peq_v;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      potl_cell #(.IDX_W(IDX_W), .INDEX(g)) u_cell (
        .clk(clk), .ctl(ctl),
        .from_left (slots[(g == 0) ? 0 : g - 1]),
        .from_right(slots[(g == DEPTH - 1) ? g : g + 1]),
        .head_slot (slots[0]),
        .tail_slot (slots[count == 0 ? 0 : IDX_W'(count - 1'b1)]),
        .slot(slots[g]), .pri_gt(gt_v[g]), .num_eq(eq_v[g]), .pri_eq(peq_v[g]));
    end
  endgenerate

  // Valid mask and search results over the occupied cells.
  logic [DEPTH-1:0] occ;
  logic [IDX_W:0]   ins_pos;
  logic             found;
  logic [IDX_W-1:0] fidx;
  always_comb begin
    for (int i = 0; i < DEPTH; i++) occ[i] = CNT_W'(i) < count;
    // Insert point is just after the last held task whose priority is not
    // greater; moves can leave the list out of priority order.
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++)
      if (occ[i] && !gt_v[i]) ins_pos = (IDX_W+1)'(i + 1);
    found = 1'b0;
    fidx  = '0;
    for (int i = DEPTH - 1; i >= 0; i--)
      if (occ[i] && eq_v[i]) begin
        found = 1'b1;
        fidx  = IDX_W'(i);
      end
  end

  logic [IDX_W-1:0] lastidx;
  assign lastidx = IDX_W'(count - 1'b1);

  function automatic logic [SUM_W-1:0] tmin(input slot_t s);
    return SUM_W'({s.hr, 6'd0} - {2'd0, s.hr, 2'd0}) + SUM_W'(s.mn);
  endfunction

  logic [5:0] mn_clip;
  assign mn_clip = (req.minutes > 6'd59) ? 6'd59 : req.minutes;

  // Priority fix-up after a move: both neighbor slots sit at fixed places.
  slot_t fix_a, fix_b;
  assign fix_a = slots[fixpos];
  assign fix_b = slots[(fixpos == IDX_W'(DEPTH - 1)) ? fixpos : fixpos + 1'b1];

  // Control word, driven from state and the latched request.
  always_comb begin
    ctl      = '0;
    ctl.op   = OP_HOLD;
    ctl.last = 11'(lastidx);
    ctl.pri  = rq.priority_req;
    ctl.num  = rq.task_number;
    ctl.ins  = carry;
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_DONE;
        case (kind_t'(rq.kind))
          K_PUSH: if (count < CNT_W'(DEPTH)) begin
            ctl.op   = OP_INSERT;
            ctl.pos  = 11'(ins_pos);
            ctl.last = 11'(count) - 11'd1;
          end
          K_QUERY: state_next = (count == 0) ? S_DONE : S_SUM;
          K_POP: if (count != 0) begin
            ctl.op  = OP_DELETE;
            ctl.pos = 11'(lastidx);
          end
          K_REMOVE, K_CHPRI: if (count != 0 && found) begin
            ctl.op  = OP_DELETE;
            ctl.pos = 11'(fidx);
            if (kind_t'(rq.kind) == K_CHPRI) state_next = S_INS;
          end
          K_UP: if (count > 1 && found) begin
            if (fidx == 0) ctl.op = OP_ROTL;
            else begin
              ctl.op  = OP_SWAP;
              ctl.pos = 11'(fidx - 1'b1);
            end
            state_next = S_FIX;
          end
          K_DOWN: if (count > 1 && found) begin
            if (fidx == lastidx) ctl.op = OP_ROTR;
            else begin
              ctl.op  = OP_SWAP;
              ctl.pos = 11'(fidx);
              state_next = S_FIX;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_INS: begin
        ctl.op   = OP_INSERT;
        ctl.pos  = 11'(ins_pos);
        ctl.last = 11'(count) - 11'd1;
        state_next = S_DONE;
      end
      S_FIX: begin
        state_next = S_DONE;
        if (fixen) begin
          case (fixmode)
            FX_UP_SWAP: if (fix_b.pri < fix_a.pri) begin
              ctl.op  = OP_SETPRI;
              ctl.pos = 11'(fixpos);
              ctl.pri = fix_b.pri;
            end
            FX_UP_WRAP: if (fix_a.pri < fix_b.pri) begin
              ctl.op  = OP_SETPRI;
              ctl.pos = 11'(fixpos) + 11'd1;
              ctl.pri = fix_a.pri;
            end
            default: if (fix_a.pri > fix_b.pri) begin
              ctl.op  = OP_SETPRI;
              ctl.pos = 11'(fixpos) + 11'd1;
              ctl.pri = fix_a.pri;
            end
          endcase
        end
      end
      S_SUM: if (walk == lastidx) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (start) begin
          rq <= req;
          st <= ST_OK;
          popped <= '0;
          qsum <= '0;
          walk <= '0;
          fixen <= 1'b0;
          // A push carries its task into the chain from here.
          if (kind_t'(req.kind) == K_PUSH)
            carry <= '{num: req.task_number, pri: req.priority_req, hr: req.hours,
                       mn: mn_clip};
        end
        S_EXEC: begin
          case (kind_t'(rq.kind))
            K_PUSH: if (count < CNT_W'(DEPTH)) begin
              count <= count + 1'b1;
              total <= total + tmin(carry);
            end else st <= ST_FULL;
            K_QUERY: ;
            K_NONE: ;
            default: if (count == 0) st <= ST_EMPTY;
              else if (kind_t'(rq.kind) == K_POP) begin
                popped <= slots[lastidx];
                count  <= count - 1'b1;
                total  <= total - tmin(slots[lastidx]);
              end else if (!found) st <= ST_NOT_FOUND;
              else if (kind_t'(rq.kind) == K_REMOVE || kind_t'(rq.kind) == K_CHPRI) begin
                count <= count - 1'b1;
                total <= total - tmin(slots[fidx]);
                carry <= '{num: slots[fidx].num, pri: rq.priority_req,
                           hr: slots[fidx].hr, mn: slots[fidx].mn};
              end else if (kind_t'(rq.kind) == K_UP) begin
                fixen   <= count > 1;
                fixpos  <= (fidx == 0) ? lastidx - 1'b1 : fidx - 1'b1;
                // Up: the moved task lands at fixpos (swap) or at the tail.
                fixmode <= (fidx == 0) ? FX_UP_WRAP : FX_UP_SWAP;
              end else begin
                fixen   <= count > 1;
                fixpos  <= fidx;
                fixmode <= FX_DOWN;
              end
          endcase
        end
        S_INS: begin
          count <= count + 1'b1;
          total <= total + tmin(carry);
        end
        S_SUM: begin
          if (slots[walk].pri == rq.priority_req) qsum <= qsum + tmin(slots[walk]);
          walk <= walk + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    rsp = '0;
    rsp.status          = st;
    rsp.out_task_number = popped.num;
    rsp.out_priority    = popped.pri;
    rsp.out_hours       = (kind_t'(rq.kind) == K_QUERY) ? div60(qsum) : 14'(popped.hr);
    rsp.out_minutes     = (kind_t'(rq.kind) == K_QUERY) ? mod60(qsum) : popped.mn;
    rsp.entry_count     = (count > CNT_W'(63)) ? 6'd63 : 6'(count);
    rsp.total_hours     = div60(total);
    rsp.total_minutes   = mod60(total);
  end

  logic unused_peq;
  assign unused_peq = ^peq_v;

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for two cycles");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> (state != S_EXEC) || $past(state) == S_IDLE)
    else $error("accept while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("count above depth");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && kind_t'(rq.kind) == K_PUSH && count == CNT_W'(DEPTH))
    |=> $stable(count))
    else $error("push into full list changed count");
endmodule
`default_nettype wire
